// File: src/tcc_pkg.sv
// Shared types, codes and helper functions for the text console cursor controller.
package tcc_pkg;

    // Request codes
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_ERASE = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // Drawing command codes
    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_GLYPH  = 2'd1;
    localparam logic [1:0] CMD_SCROLL = 2'd2;
    localparam logic [1:0] CMD_FILL   = 2'd3;

    // Erase line modes
    localparam logic [1:0] ERASE_TO_END     = 2'd0;
    localparam logic [1:0] ERASE_FROM_START = 2'd1;
    localparam logic [1:0] ERASE_WHOLE      = 2'd2;
    localparam logic [1:0] ERASE_TO_END_ALT = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_TEXT_COLS     = 3'd0;
    localparam logic [2:0] CFG_TEXT_ROWS     = 3'd1;
    localparam logic [2:0] CFG_GLYPH_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_GLYPH_HEIGHT  = 3'd3;
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd5;
    localparam logic [2:0] CFG_FG_COLOR      = 3'd6;
    localparam logic [2:0] CFG_BG_COLOR      = 3'd7;

    // Character codes with special handling
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [9:0]  MAX_TEXT   = 10'd512;
    localparam logic [12:0] MAX_SCREEN = 13'd4096;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [8:0] target_row;
        logic [8:0] target_col;
        logic [1:0] erase_mode;
    } req_t;

    typedef struct packed {
        logic [9:0]  text_cols;
        logic [9:0]  text_rows;
        logic [5:0]  glyph_width;
        logic [5:0]  glyph_height;
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [23:0] fg_color;
        logic [23:0] bg_color;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  glyph_code;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [12:0] rect_w;
        logic [12:0] rect_h;
        logic [23:0] draw_fg;
        logic [23:0] draw_bg;
    } res_t;

    // Up to three results of one request in fixed slot order:
    // slot 0 glyph, slot 1 scroll, slot 2 fill.
    typedef struct packed {
        res_t [2:0] res;
        logic [2:0] mask;
        logic [8:0] cursor_row;
        logic [8:0] cursor_col;
    } batch_t;

    localparam res_t RES_NONE = '{cmd: CMD_NONE, glyph_code: 8'd0, pixel_x: 12'd0,
                                  pixel_y: 12'd0, rect_w: 13'd0, rect_h: 13'd0,
                                  draw_fg: 24'd0, draw_bg: 24'd0};

    function automatic logic [9:0] eff_text(input logic [9:0] v);
        if (v == 10'd0)
            return 10'd1;
        return (v > MAX_TEXT) ? MAX_TEXT : v;
    endfunction

    function automatic logic [12:0] eff_screen(input logic [12:0] v);
        return (v > MAX_SCREEN) ? MAX_SCREEN : v;
    endfunction

endpackage

// File: src/tcc_exec.sv
// Request evaluation: next cursor and the drawing commands of one request.
module tcc_exec
    import tcc_pkg::*;
(
    input  req_t       req,
    input  cfg_t       cfg,
    input  logic [8:0] cursor_row,
    input  logic [8:0] cursor_col,
    output batch_t     batch
);

    logic [9:0]  cols_e;
    logic [9:0]  rows_e;
    logic [9:0]  rows_m1;
    logic [12:0] sw_e;
    logic [12:0] sh_e;
    logic [9:0]  row_p1;
    logic [9:0]  col_p1;
    logic        is_put;
    logic        is_bs;
    logic        is_nl;
    logic        is_cr;
    logic        is_print;
    logic        scroll;
    logic [8:0]  nr_row;
    logic        wrap;
    logic [8:0]  bs_row;
    logic [8:0]  bs_col;
    logic [8:0]  g_row;
    logic [8:0]  g_col;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [15:0] colsw;
    logic [15:0] lasty;
    logic        glyph_on;
    logic        glyph_act;
    logic        scroll_act;
    logic        fill_req;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] fw;
    logic [12:0] fh;
    logic [16:0] x_end;
    logic [16:0] y_end;
    logic [15:0] wc;
    logic [12:0] hc;
    logic        fill_ok;
    logic [8:0]  row_next;
    logic [8:0]  col_next;
    res_t        glyph_res;
    res_t        scroll_res;
    res_t        fill_res;
    logic [2:0]  mask;

    assign cols_e  = eff_text(cfg.text_cols);
    assign rows_e  = eff_text(cfg.text_rows);
    assign rows_m1 = rows_e - 10'd1;
    assign sw_e    = eff_screen(cfg.screen_width);
    assign sh_e    = eff_screen(cfg.screen_height);
    assign row_p1  = {1'b0, cursor_row} + 10'd1;
    assign col_p1  = {1'b0, cursor_col} + 10'd1;

    assign is_put   = (req.req_type == REQ_PUT);
    assign is_bs    = is_put && (req.char_code == CH_BACKSPACE);
    assign is_nl    = is_put && (req.char_code == CH_NEWLINE);
    assign is_cr    = is_put && (req.char_code == CH_RETURN);
    assign is_print = is_put && (req.char_code >= CH_SPACE);

    // Advancing the row scrolls once the cursor passes the last text row.
    assign scroll = (row_p1 >= rows_e);
    assign nr_row = scroll ? rows_m1[8:0] : row_p1[8:0];
    assign wrap   = (col_p1 >= cols_e);

    // Backspace wraps from column zero to the end of the previous row.
    always_comb
    begin
        bs_row = cursor_row;
        bs_col = cursor_col;
        if (cursor_col != 9'd0)
        begin
            bs_col = cursor_col - 9'd1;
        end
        else if (cursor_row != 9'd0)
        begin
            bs_row = cursor_row - 9'd1;
            bs_col = 9'(cols_e - 10'd1);
        end
    end

    // Backspace draws at the new cursor, everything else at the old one.
    assign g_row = is_bs ? bs_row : cursor_row;
    assign g_col = is_bs ? bs_col : cursor_col;

    assign gx    = 16'(g_col) * 16'(cfg.glyph_width);
    assign gy    = 16'(g_row) * 16'(cfg.glyph_height);
    assign colsw = 16'(cols_e) * 16'(cfg.glyph_width);
    assign lasty = 16'(rows_m1) * 16'(cfg.glyph_height);

    assign glyph_on   = (gx < 16'(sw_e)) && (gy < 16'(sh_e));
    assign glyph_act  = is_bs || is_print;
    assign scroll_act = scroll && (is_nl || (is_print && wrap));

    // Fill rectangle before clipping.
    always_comb
    begin
        fx       = 16'd0;
        fy       = 16'd0;
        fw       = 16'd0;
        fh       = 13'(cfg.glyph_height);
        fill_req = 1'b0;
        unique case (req.req_type)
            REQ_PUT:
            begin
                fy       = lasty;
                fw       = 16'(sw_e);
                fill_req = scroll_act;
            end
            REQ_SET:
            begin
                fill_req = 1'b0;
            end
            REQ_ERASE:
            begin
                fy       = gy;
                fill_req = 1'b1;
                unique case (req.erase_mode) inside
                    ERASE_FROM_START:
                    begin
                        fw = gx + 16'(cfg.glyph_width);
                    end
                    ERASE_WHOLE:
                    begin
                        fw = colsw;
                    end
                    ERASE_TO_END, ERASE_TO_END_ALT:
                    begin
                        fx = gx;
                        fw = ({1'b0, cursor_col} < cols_e) ? (colsw - gx) : 16'd0;
                    end
                    default:
                    begin
                        fw = 16'd0;
                    end
                endcase
            end
            REQ_CLEAR:
            begin
                fw       = 16'(sw_e);
                fh       = sh_e;
                fill_req = 1'b1;
            end
            default:
            begin
                fill_req = 1'b0;
            end
        endcase
    end

    // Clip the fill against the right and bottom screen edges.
    assign x_end   = 17'(fx) + 17'(fw);
    assign y_end   = 17'(fy) + 17'(fh);
    assign wc      = (x_end > 17'(sw_e)) ? (16'(sw_e) - fx) : fw;
    assign hc      = (y_end > 17'(sh_e)) ? (sh_e - fy[12:0]) : fh;
    assign fill_ok = fill_req && (fx < 16'(sw_e)) && (fy < 16'(sh_e))
                     && (wc != 16'd0) && (hc != 13'd0);

    // Cursor after the request.
    always_comb
    begin
        row_next = cursor_row;
        col_next = cursor_col;
        unique case (req.req_type) inside
            REQ_PUT:
            begin
                if (is_nl)
                begin
                    col_next = 9'd0;
                    row_next = nr_row;
                end
                else if (is_cr)
                begin
                    col_next = 9'd0;
                end
                else if (is_bs)
                begin
                    row_next = bs_row;
                    col_next = bs_col;
                end
                else if (is_print)
                begin
                    col_next = wrap ? 9'd0 : col_p1[8:0];
                    row_next = wrap ? nr_row : cursor_row;
                end
            end
            REQ_SET:
            begin
                row_next = ({1'b0, req.target_row} < rows_e) ? req.target_row
                                                             : rows_m1[8:0];
                col_next = ({1'b0, req.target_col} < cols_e) ? req.target_col
                                                             : 9'(cols_e - 10'd1);
            end
            REQ_ERASE, REQ_CLEAR:
            begin
                row_next = cursor_row;
            end
            default:
            begin
                row_next = cursor_row;
            end
        endcase
    end

    always_comb
    begin
        glyph_res = RES_NONE;
        if (glyph_act && glyph_on)
        begin
            glyph_res.cmd        = CMD_GLYPH;
            glyph_res.glyph_code = is_bs ? CH_SPACE : req.char_code;
            glyph_res.pixel_x    = gx[11:0];
            glyph_res.pixel_y    = gy[11:0];
            glyph_res.draw_fg    = cfg.fg_color;
            glyph_res.draw_bg    = cfg.bg_color;
        end

        scroll_res     = RES_NONE;
        scroll_res.cmd = CMD_SCROLL;

        fill_res         = RES_NONE;
        fill_res.cmd     = CMD_FILL;
        fill_res.pixel_x = fx[11:0];
        fill_res.pixel_y = fy[11:0];
        fill_res.rect_w  = wc[12:0];
        fill_res.rect_h  = hc;
        fill_res.draw_bg = cfg.bg_color;
    end

    // An empty request still reports the cursor through slot zero, which then
    // holds a nothing-to-draw result.
    assign mask = {fill_ok, scroll_act, glyph_act};

    assign batch.res        = {fill_res, scroll_res, glyph_res};
    assign batch.mask       = (mask == 3'b000) ? 3'b001 : mask;
    assign batch.cursor_row = row_next;
    assign batch.cursor_col = col_next;

endmodule

// File: src/tcc_outq.sv
// Result register that hands out the pending results of one request, one beat each.
module tcc_outq
    import tcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  batch_t     batch,
    output logic       ready,
    output logic       out_valid,
    input  logic       out_stall,
    output res_t       out_res,
    output logic [8:0] out_row,
    output logic [8:0] out_col,
    output logic       out_last
);

    batch_t     batch_reg;
    logic [2:0] mask_reg;
    logic [2:0] mask_next;
    logic [2:0] sel_oh;
    logic [2:0] remain;
    logic [1:0] sel_idx;
    logic       beat;

    assign sel_oh  = mask_reg & (~mask_reg + 3'd1);
    assign remain  = mask_reg & ~sel_oh;
    assign sel_idx = mask_reg[0] ? 2'd0 : (mask_reg[1] ? 2'd1 : 2'd2);

    assign out_valid = (mask_reg != 3'b000);
    assign out_last  = (remain == 3'b000);
    assign beat      = out_valid && !out_stall;
    assign ready     = !out_valid || (beat && out_last);

    assign out_res = batch_reg.res[sel_idx];
    assign out_row = batch_reg.cursor_row;
    assign out_col = batch_reg.cursor_col;

    always_comb
    begin
        mask_next = mask_reg;
        if (beat)
            mask_next = remain;
        if (load && ready)
            mask_next = batch.mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= 3'b000;
        else
            mask_reg <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && ready)
            batch_reg <= batch;
    end

endmodule

// File: src/text_console_cursor_controller.sv
// Top level of the text console cursor controller: ports, registers and checks.
// Flow: a request is accepted into the request register, then moved into the result register,
// which presents its first result. Throughput: one result beat per cycle while out_stall is low;
// a request has one to three results, which the single result register sends in turn.
// Reset: the cursor goes to row 0, column 0, the registers take their power-on values
// and both the request register and the result register are emptied.
module text_console_cursor_controller
    import tcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,

    // Request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  char_code,
    input  logic [8:0]  target_row,
    input  logic [8:0]  target_col,
    input  logic [1:0]  erase_mode,

    // Drawing command channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  cmd,
    output logic [7:0]  glyph_code,
    output logic [11:0] pixel_x,
    output logic [11:0] pixel_y,
    output logic [12:0] rect_w,
    output logic [12:0] rect_h,
    output logic [23:0] draw_fg,
    output logic [23:0] draw_bg,
    output logic [8:0]  cursor_row_out,
    output logic [8:0]  cursor_col_out,
    output logic        last
);

    // Configuration registers. The user must change them only while the block is idle; the block does
    // not enforce this, and the evaluation logic reads them directly.
    cfg_t       cfg_reg;

    // Request register: holds one accepted beat until the result register can
    // take its results. It refills in the same cycle it drains, so a new request
    // is taken every cycle while each request yields a single result and out_stall is low.
    req_t       req_reg;
    logic       req_full_reg;
    logic       req_full_next;

    // Cursor state. It advances when a request moves into the result register,
    // so the next request is always evaluated against an up-to-date cursor.
    logic [8:0] cursor_row_reg;
    logic [8:0] cursor_col_reg;

    batch_t     batch;
    logic       q_ready;
    logic       move;
    res_t       out_res;

    assign move     = req_full_reg && q_ready;
    assign in_stall = req_full_reg && !q_ready;

    always_comb
    begin
        req_full_next = req_full_reg;
        if (!in_stall)
            req_full_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_full_reg <= 1'b0;
        else
            req_full_reg <= req_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg.req_type   <= req_type;
            req_reg.char_code  <= char_code;
            req_reg.target_row <= target_row;
            req_reg.target_col <= target_col;
            req_reg.erase_mode <= erase_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg <= 9'd0;
            cursor_col_reg <= 9'd0;
        end
        else if (move)
        begin
            cursor_row_reg <= batch.cursor_row;
            cursor_col_reg <= batch.cursor_col;
        end
    end

    // Register writes; every index of the port maps to a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.text_cols     <= 10'd100;
            cfg_reg.text_rows     <= 10'd37;
            cfg_reg.glyph_width   <= 6'd8;
            cfg_reg.glyph_height  <= 6'd16;
            cfg_reg.screen_width  <= 13'd800;
            cfg_reg.screen_height <= 13'd600;
            cfg_reg.fg_color      <= 24'hC0C0C0;
            cfg_reg.bg_color      <= 24'h000080;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEXT_COLS:     cfg_reg.text_cols     <= cfg_data[9:0];
                CFG_TEXT_ROWS:     cfg_reg.text_rows     <= cfg_data[9:0];
                CFG_GLYPH_WIDTH:   cfg_reg.glyph_width   <= cfg_data[5:0];
                CFG_GLYPH_HEIGHT:  cfg_reg.glyph_height  <= cfg_data[5:0];
                CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data[12:0];
                CFG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data[12:0];
                CFG_FG_COLOR:      cfg_reg.fg_color      <= cfg_data;
                CFG_BG_COLOR:      cfg_reg.bg_color      <= cfg_data;
                default:           cfg_reg.bg_color      <= cfg_reg.bg_color;
            endcase
        end
    end

    // Single pass from the request register to the result register: cursor
    // update, glyph placement, scroll and a clipped fill.
    tcc_exec u_exec
    (
        .req        (req_reg),
        .cfg        (cfg_reg),
        .cursor_row (cursor_row_reg),
        .cursor_col (cursor_col_reg),
        .batch      (batch)
    );

    // Result register: sends glyph, scroll and fill beats in that order, each
    // carrying the cursor as it stands after the whole request.
    tcc_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (move),
        .batch     (batch),
        .ready     (q_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res),
        .out_row   (cursor_row_out),
        .out_col   (cursor_col_out),
        .out_last  (last)
    );

    assign cmd        = out_res.cmd;
    assign glyph_code = out_res.glyph_code;
    assign pixel_x    = out_res.pixel_x;
    assign pixel_y    = out_res.pixel_y;
    assign rect_w     = out_res.rect_w;
    assign rect_h     = out_res.rect_h;
    assign draw_fg    = out_res.draw_fg;
    assign draw_bg    = out_res.draw_bg;

    // A request with more results to send keeps the channel valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |=> out_valid)
        else $error("result channel dropped pending results of a request");

    // A fill is always the final command of its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (cmd == CMD_FILL)) |-> last)
        else $error("fill command not marked as the final beat");

    // The cursor only moves when a request is handed to the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !move |=> ($stable(cursor_row_reg) && $stable(cursor_col_reg)))
        else $error("cursor changed without a request being processed");

    // While a request is still sending, the next one must wait in its register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> !move)
        else $error("request moved before the previous one finished");

endmodule
